[hdl/nfsa_pkg.sv]
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared types, widths and codes of the next-fit slot allocator
// ----------------------------------------------------------------------------
package nfsa_pkg;

	// field widths
	localparam int CFG_W    = 6;
	localparam int SLOT_W   = 5;
	localparam int CNT_W    = 6;
	localparam int STATUS_W = 2;

	// default pool depth and the highest slot count the register can name
	localparam int NUM_SLOTS_DEF = 32;
	localparam int SCAN_MAX      = 63;

	// register reset value
	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

	// action codes
	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

	// operation after classification
	typedef enum logic [1:0] {
		OP_ACQUIRE,
		OP_RELEASE,
		OP_REJECT
	} op_t;

	// one queued transaction
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
	} q_entry_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// back end sequencer
	typedef enum logic {
		BK_IDLE,
		BK_COMMIT
	} back_state_t;

endpackage

[hdl/next_fit_slot_allocator.sv]
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// pool of slots with next-fit acquire and indexed release
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | action, slot
// rsp     | out       | rsp_valid/rsp_stall  | status, granted_slot, active_count
// cfg     | in        | cfg_wr_en            | cfg_wr_data (slots_in_use)
//
// each transaction passes through the back end in steps: the idle state captures the
// candidate free-slot vectors, the commit state does the find-first, state update and response load.
// a two-entry queue lets requests arrive while the back end is busy.
// reset clears every slot, the search position and the count; no sweep.
// a stalled response holds the back end in its commit cycle.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator #(
	parameter int NUM_SLOTS = nfsa_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [nfsa_pkg::CFG_W-1:0]       cfg_wr_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             action,
	input  logic [nfsa_pkg::SLOT_W-1:0]      slot,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [nfsa_pkg::STATUS_W-1:0]    status,
	output logic [nfsa_pkg::SLOT_W-1:0]      granted_slot,
	output logic [nfsa_pkg::CNT_W-1:0]       active_count
);

	logic [nfsa_pkg::CNT_W-1:0] eff_slots;
	nfsa_pkg::q_status_t        q_stat;
	nfsa_pkg::q_entry_t         push_entry;
	nfsa_pkg::q_entry_t         head;
	logic                       push;
	logic                       pop;

	// request classification
	nfsa_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.slot       (slot),
		.eff_slots  (eff_slots),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	nfsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// execution and response
	nfsa_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.eff_slots    (eff_slots),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.granted_slot (granted_slot),
		.active_count (active_count)
	);

endmodule

[hdl/nfsa_front.sv]
// ----------------------------------------------------------------------------
// nfsa_front
// accepts request transactions and classifies them for the back end
// ----------------------------------------------------------------------------
module nfsa_front (
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           action,
	input  logic [nfsa_pkg::SLOT_W-1:0]    slot,
	input  logic [nfsa_pkg::CNT_W-1:0]     eff_slots,
	input  nfsa_pkg::q_status_t            q_stat,
	output logic                           push,
	output nfsa_pkg::q_entry_t             push_entry
);

	// stall while the queue has no room
	assign req_stall = q_stat.full;
	assign push      = req_valid && !q_stat.full;

	// classify: a release outside the managed range is rejected up front
	always_comb begin
		push_entry.slot = slot;
		unique case (action)
			nfsa_pkg::ACT_RELEASE: begin
				if (nfsa_pkg::CNT_W'(slot) < eff_slots)
					push_entry.op = nfsa_pkg::OP_RELEASE;
				else
					push_entry.op = nfsa_pkg::OP_REJECT;
			end
			default: push_entry.op = nfsa_pkg::OP_ACQUIRE;
		endcase
	end

endmodule

[hdl/nfsa_queue.sv]
// ----------------------------------------------------------------------------
// nfsa_queue
// two-entry queue between the front and the back end
// ----------------------------------------------------------------------------
module nfsa_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nfsa_pkg::q_entry_t   push_entry,
	input  logic                 pop,
	output nfsa_pkg::q_entry_t   head,
	output nfsa_pkg::q_status_t  q_stat
);

	nfsa_pkg::q_entry_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

[hdl/nfsa_back.sv]
// ----------------------------------------------------------------------------
// nfsa_back
// slot state, next-fit search and the response register
// ----------------------------------------------------------------------------
module nfsa_back #(
	parameter int NUM_SLOTS = nfsa_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [nfsa_pkg::CFG_W-1:0]       cfg_wr_data,
	output logic [nfsa_pkg::CNT_W-1:0]       eff_slots,
	input  nfsa_pkg::q_status_t              q_stat,
	input  nfsa_pkg::q_entry_t               head,
	output logic                             pop,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [nfsa_pkg::STATUS_W-1:0]    status,
	output logic [nfsa_pkg::SLOT_W-1:0]      granted_slot,
	output logic [nfsa_pkg::CNT_W-1:0]       active_count
);

	localparam int CNT_W  = nfsa_pkg::CNT_W;
	localparam int SCAN_N = (NUM_SLOTS < nfsa_pkg::SCAN_MAX) ? NUM_SLOTS : nfsa_pkg::SCAN_MAX;
	localparam int IDX_W  = $clog2(SCAN_N);

	// lowest set bit of a candidate vector
	function automatic logic [IDX_W-1:0] first_set(input logic [SCAN_N-1:0] vec);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = SCAN_N - 1; i >= 0; i--) begin
			if (vec[i])
				r = IDX_W'(i);
		end
		return r;
	endfunction

	logic [nfsa_pkg::CFG_W-1:0] slots_q;
	logic [SCAN_N-1:0]          flags_q;
	logic [CNT_W-1:0]           search_q;
	logic [CNT_W-1:0]           used_q;
	nfsa_pkg::back_state_t      state_q, state_d;

	nfsa_pkg::op_t              op_s1;
	logic [IDX_W-1:0]           slot_s1;
	logic                       hit_s1;
	logic [SCAN_N-1:0]          cand_hi_s1;
	logic [SCAN_N-1:0]          cand_lo_s1;

	logic                       rsp_valid_q;
	logic [nfsa_pkg::STATUS_W-1:0] status_q;
	logic [nfsa_pkg::SLOT_W-1:0]   granted_q;
	logic [CNT_W-1:0]           count_q;

	logic                       out_free;
	logic                       load_s1;
	logic                       commit;
	logic [CNT_W-1:0]           start_c;
	logic [CNT_W:0]             slot_wide;
	logic [IDX_W-1:0]           head_idx;
	logic [SCAN_N-1:0]          cand_hi_c;
	logic [SCAN_N-1:0]          cand_lo_c;
	logic                       found_c;
	logic [IDX_W-1:0]           pick_c;
	logic                       take_c;
	logic                       free_c;
	logic [CNT_W-1:0]           used_d;
	logic [CNT_W-1:0]           search_d;
	logic [nfsa_pkg::STATUS_W-1:0] res_status;
	logic [nfsa_pkg::SLOT_W-1:0]   res_grant;

	// effective slot count, clamped to the pool depth
	assign eff_slots = (int'(slots_q) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS) : slots_q;
	assign start_c   = (search_q < eff_slots) ? search_q : eff_slots;

	// candidate free slots above and below the search position
	always_comb begin
		for (int i = 0; i < SCAN_N; i++) begin
			cand_hi_c[i] = !flags_q[i] && (CNT_W'(i) >= start_c) && (CNT_W'(i) < eff_slots);
			cand_lo_c[i] = !flags_q[i] && (CNT_W'(i) < start_c);
		end
	end

	// release slot index at the pool's index width
	assign slot_wide = (CNT_W + 1)'(head.slot);
	assign head_idx  = slot_wide[IDX_W-1:0];

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfsa_pkg::BK_IDLE:   if (!q_stat.empty) state_d = nfsa_pkg::BK_COMMIT;
			nfsa_pkg::BK_COMMIT: if (out_free) state_d = nfsa_pkg::BK_IDLE;
			default:             state_d = nfsa_pkg::BK_IDLE;
		endcase
	end

	// sequencer: outputs
	assign out_free = !rsp_valid_q || !rsp_stall;
	always_comb begin
		load_s1 = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			nfsa_pkg::BK_IDLE:   load_s1 = !q_stat.empty;
			nfsa_pkg::BK_COMMIT: commit  = out_free;
			default: ;
		endcase
	end
	assign pop = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nfsa_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	// first stage: capture the transaction and the candidate vectors
	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1      <= head.op;
			slot_s1    <= head_idx;
			hit_s1     <= (head.op == nfsa_pkg::OP_RELEASE) && flags_q[head_idx];
			cand_hi_s1 <= cand_hi_c;
			cand_lo_s1 <= cand_lo_c;
		end
	end

	// second stage: pick the slot and form the result
	assign found_c = (|cand_hi_s1) || (|cand_lo_s1);
	assign pick_c  = (|cand_hi_s1) ? first_set(cand_hi_s1) : first_set(cand_lo_s1);

	always_comb begin
		take_c     = 1'b0;
		free_c     = 1'b0;
		used_d     = used_q;
		search_d   = search_q;
		res_status = nfsa_pkg::ST_NOT_ACTIVE;
		res_grant  = '0;
		unique case (op_s1)
			nfsa_pkg::OP_ACQUIRE: begin
				if (found_c) begin
					take_c     = 1'b1;
					used_d     = used_q + CNT_W'(1);
					search_d   = CNT_W'(pick_c) + CNT_W'(1);
					res_status = nfsa_pkg::ST_OK;
					res_grant  = nfsa_pkg::SLOT_W'(CNT_W'(pick_c));
				end else begin
					res_status = nfsa_pkg::ST_FULL;
				end
			end
			nfsa_pkg::OP_RELEASE: begin
				if (hit_s1) begin
					free_c     = 1'b1;
					used_d     = used_q - CNT_W'(1);
					if (CNT_W'(slot_s1) < search_q)
						search_d = CNT_W'(slot_s1);
					res_status = nfsa_pkg::ST_OK;
					res_grant  = nfsa_pkg::SLOT_W'(CNT_W'(slot_s1));
				end
			end
			default: ;
		endcase
	end

	// pool state and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= nfsa_pkg::CFG_RESET;
			flags_q  <= '0;
			search_q <= '0;
			used_q   <= '0;
		end else if (cfg_wr_en) begin
			slots_q  <= cfg_wr_data;
			flags_q  <= '0;
			search_q <= '0;
			used_q   <= '0;
		end else if (commit) begin
			if (take_c)
				flags_q[pick_c] <= 1'b1;
			if (free_c)
				flags_q[slot_s1] <= 1'b0;
			search_q <= search_d;
			used_q   <= used_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (commit)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q  <= res_status;
			granted_q <= res_grant;
			count_q   <= used_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign active_count = count_q;

endmodule

[hdl/nfsa_checker.sv]
// ----------------------------------------------------------------------------
// nfsa_checker
// port-level assertions for the next-fit slot allocator
// ----------------------------------------------------------------------------
module nfsa_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rsp_valid,
	input  logic                             rsp_stall,
	input  logic [nfsa_pkg::STATUS_W-1:0]    status,
	input  logic [nfsa_pkg::SLOT_W-1:0]      granted_slot,
	input  logic [nfsa_pkg::CNT_W-1:0]       active_count
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
		$stable(granted_slot) && $stable(active_count))
		else $error("response changed while stalled");

	// status carries one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == nfsa_pkg::ST_OK) || (status == nfsa_pkg::ST_FULL) ||
		(status == nfsa_pkg::ST_NOT_ACTIVE))
		else $error("undefined status code");

	// a full pool grants nothing
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == nfsa_pkg::ST_FULL) |-> granted_slot == '0)
		else $error("full response with nonzero slot");

	// a failed release reports slot zero
	a_reject_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == nfsa_pkg::ST_NOT_ACTIVE) |-> granted_slot == '0)
		else $error("not-active response with nonzero slot");

endmodule

bind next_fit_slot_allocator nfsa_checker u_nfsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.status       (status),
	.granted_slot (granted_slot),
	.active_count (active_count)
);
